// ===== rtl/sound_channel_allocator_core_defines.svh =====
// Assertion macros for the voice allocator core.
`ifndef SOUND_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH
`define SOUND_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i while out of reset.
`define SCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sca: same-cycle check failed");

// Next-cycle implication, checked on clk_i while out of reset.
`define SCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sca: next-cycle check failed");

`endif

// ===== rtl/sca_pkg.sv =====
// Package of the voice allocator: field widths, codes and shared types.
package sca_pkg;

  localparam int unsigned ENT_W          = 16;
  localparam int unsigned SUB_W          = 4;
  localparam int unsigned TIME_W         = 31;
  localparam int unsigned LEN_W          = 24;
  localparam int unsigned END_W          = 32;
  localparam int unsigned LIFE_W         = 34;
  localparam int unsigned VIDX_W         = 6;
  localparam int unsigned NUM_VOICES_DEF = 8;

  localparam logic signed [LIFE_W-1:0] LIFE_START = 34'sh0_7fff_ffff;
  localparam logic [SUB_W-1:0]         SUB_ANY    = 4'hF;
  localparam logic [SUB_W-1:0]         SUB_NEVER  = 4'h0;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // Search record handed from cell to cell.
  typedef struct packed {
    req_e                      req;
    logic [ENT_W-1:0]          ent;
    logic [SUB_W-1:0]          sub;
    logic [TIME_W-1:0]         now;
    logic                      done;
    logic                      hit;
    logic [VIDX_W-1:0]         idx;
    logic signed [LIFE_W-1:0]  life;
  } scan_t;

  // Table update broadcast to all cells.
  typedef struct packed {
    logic                 en;
    logic                 clr;
    logic                 stop;
    logic [VIDX_W-1:0]    idx;
    logic [ENT_W-1:0]     owner;
    logic [SUB_W-1:0]     sub;
    logic [END_W-1:0]     end_time;
  } wr_t;

endpackage

// ===== rtl/sca_in_if.sv =====
// Request channel interface of the voice allocator.
interface sca_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic [sca_pkg::ENT_W-1:0]          entity;
  logic signed [sca_pkg::SUB_W-1:0]   ent_channel;
  logic [sca_pkg::TIME_W-1:0]         now_time;
  logic [sca_pkg::LEN_W-1:0]          sound_length;

  modport source (
    output valid, req_type, entity, ent_channel, now_time, sound_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, entity, ent_channel, now_time, sound_length,
    output ready
  );
endinterface

// ===== rtl/sca_out_if.sv =====
// Result channel interface of the voice allocator.
interface sca_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [sca_pkg::VIDX_W-1:0]   voice_index;

  modport source (
    output valid, found, voice_index,
    input  ready
  );
  modport sink (
    input  valid, found, voice_index,
    output ready
  );
endinterface

// ===== rtl/sound_channel_allocator_core.sv =====
// Top level of the voice allocator: request intake, cell chain, commit and result.
//
// Usage:
//   in_i carries one request item (allocate, stop, clear all); out_o returns
//   one result item (found, voice_index) per request, in order.
//   cfg_we_i/cfg_wdata_i write the listener entity; write only while idle.
//   An accepted item walks the chain of voice cells, one cell per cycle, and
//   the last cell's record is registered in fin_q. The commit
//   cycle updates the table and loads the output register.
//   A new request is accepted only in the idle state, once the previous
//   item has committed.
//   A result waiting in the output register does not block acceptance; a
//   later result waits in the commit stage until out_o is taken.
//   Reset clears the voice table, the listener register and all valids.
`include "sound_channel_allocator_core_defines.svh"

module sound_channel_allocator_core #(
  parameter int unsigned NUM_VOICES = sca_pkg::NUM_VOICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sca_pkg::ENT_W-1:0]  cfg_wdata_i,
  sca_in_if.sink                     in_i,
  sca_out_if.source                  out_o
);
  import sca_pkg::*;

  state_e             state_q, state_d;
  logic [ENT_W-1:0]   listener_q;
  logic [LEN_W-1:0]   len_q;
  scan_t              fin_q;
  logic               out_vld_q;
  logic               found_q;
  logic [VIDX_W-1:0]  idx_q;

  logic               in_acc, slot_free, commit;
  wr_t                wr;
  logic               chain_vld [NUM_VOICES+1];
  scan_t              chain_rec [NUM_VOICES+1];
  logic [NUM_VOICES-1:0] cell_vld;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listener_q <= '0;
    end else if (cfg_we_i) begin
      listener_q <= cfg_wdata_i;
    end
  end

  // head of the chain
  always_comb begin
    chain_vld[0]      = in_acc;
    chain_rec[0].req  = req_e'(in_i.req_type);
    chain_rec[0].ent  = in_i.entity;
    chain_rec[0].sub  = $unsigned(in_i.ent_channel);
    chain_rec[0].now  = in_i.now_time;
    chain_rec[0].done = 1'b0;
    chain_rec[0].hit  = 1'b0;
    chain_rec[0].idx  = '0;
    chain_rec[0].life = LIFE_START;
  end

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
    sca_voice_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .listener_i (listener_q),
      .wr_i       (wr),
      .vld_i      (chain_vld[g]),
      .rec_i      (chain_rec[g]),
      .vld_o      (chain_vld[g+1]),
      .rec_o      (chain_rec[g+1])
    );
    assign cell_vld[g] = chain_vld[g+1];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q <= in_i.sound_length;
    end
    if (chain_vld[NUM_VOICES]) begin
      fin_q <= chain_rec[NUM_VOICES];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (chain_vld[NUM_VOICES]) state_d = ST_HOLD;
      ST_HOLD: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commit outputs
  always_comb begin
    commit      = (state_q == ST_HOLD) && slot_free;
    wr.en       = 1'b0;
    wr.clr      = 1'b0;
    wr.stop     = 1'b0;
    wr.idx      = fin_q.idx;
    wr.owner    = fin_q.ent;
    wr.sub      = fin_q.sub;
    wr.end_time = {1'b0, fin_q.now} + {{(END_W-LEN_W){1'b0}}, len_q};
    if (commit) begin
      case (fin_q.req)
        REQ_ALLOC: wr.en = fin_q.hit;
        REQ_STOP: begin
          wr.en   = fin_q.hit;
          wr.stop = 1'b1;
        end
        REQ_CLEAR: wr.clr = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (commit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      found_q <= fin_q.hit;
      idx_q   <= fin_q.idx;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.found       = found_q;
  assign out_o.voice_index = idx_q;

  `SCA_ASSERT_NOW(a_one_token, 1'b1, $countones(cell_vld) <= 1)
  `SCA_ASSERT_NOW(a_tail_in_scan, chain_vld[NUM_VOICES], state_q == ST_SCAN)
  `SCA_ASSERT_NEXT(a_accept_enters, in_acc, cell_vld[0])
  `SCA_ASSERT_NOW(a_index_range, out_vld_q && found_q, idx_q < VIDX_W'(NUM_VOICES - 1) ||
                  idx_q == VIDX_W'(NUM_VOICES - 1))

endmodule

// ===== rtl/sca_voice_cell.sv =====
// One voice of the table plus one stage of the search chain.
module sca_voice_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sca_pkg::ENT_W-1:0]    listener_i,
  input  sca_pkg::wr_t                 wr_i,
  input  logic                         vld_i,
  input  sca_pkg::scan_t               rec_i,
  output logic                         vld_o,
  output sca_pkg::scan_t               rec_o
);
  import sca_pkg::*;

  logic [ENT_W-1:0]         owner_q;
  logic [SUB_W-1:0]         sub_q;
  logic [END_W-1:0]         end_q;
  logic                     active_q;
  logic                     vld_q;
  scan_t                    rec_q, rec_d;
  logic signed [LIFE_W-1:0] life;
  logic                     owner_hit, reuse, guarded, sel;

  assign sel = wr_i.en && (wr_i.idx == VIDX_W'(IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q  <= '0;
      sub_q    <= '0;
      end_q    <= '0;
      active_q <= 1'b0;
    end else if (wr_i.clr) begin
      owner_q  <= '0;
      sub_q    <= '0;
      end_q    <= '0;
      active_q <= 1'b0;
    end else if (sel) begin
      if (wr_i.stop) begin
        end_q    <= '0;
        active_q <= 1'b0;
      end else begin
        owner_q  <= wr_i.owner;
        sub_q    <= wr_i.sub;
        end_q    <= wr_i.end_time;
        active_q <= 1'b1;
      end
    end
  end

  always_comb begin
    rec_d     = rec_i;
    life      = $signed({2'b00, end_q}) - $signed({3'b000, rec_i.now});
    owner_hit = (owner_q == rec_i.ent);
    reuse     = (rec_i.sub != SUB_NEVER) && owner_hit &&
                ((sub_q == rec_i.sub) || (rec_i.sub == SUB_ANY));
    // listener's live voices are off limits to other entities
    guarded   = (owner_q == listener_i) && (rec_i.ent != listener_i) && active_q;
    case (rec_i.req)
      REQ_ALLOC: begin
        if (!rec_i.done) begin
          if (reuse) begin
            rec_d.done = 1'b1;
            rec_d.hit  = 1'b1;
            rec_d.idx  = VIDX_W'(IDX);
          end else if (!guarded && (life < rec_i.life)) begin
            rec_d.life = life;
            rec_d.hit  = 1'b1;
            rec_d.idx  = VIDX_W'(IDX);
          end
        end
      end
      REQ_STOP: begin
        if (!rec_i.done && owner_hit && (sub_q == rec_i.sub)) begin
          rec_d.done = 1'b1;
          rec_d.hit  = 1'b1;
          rec_d.idx  = VIDX_W'(IDX);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign vld_o = vld_q;
  assign rec_o = rec_q;

endmodule

// ===== test/sound_channel_allocator_core_tb.sv =====
// Self-checking testbench for the voice allocator core: directed and random requests.
`timescale 1ns / 100ps

module sound_channel_allocator_core_tb;
  import sca_pkg::*;

  localparam int NV = NUM_VOICES_DEF;

  typedef struct packed {
    req_e              kind;
    logic [ENT_W-1:0]  entity;
    logic [SUB_W-1:0]  chan;
    logic [TIME_W-1:0] now;
    logic [LEN_W-1:0]  len;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [VIDX_W-1:0] idx;
  } outcome_t;

  // Tracks the voice table and queues the outcome each accepted item should produce.
  class voice_alloc_scoreboard;
    logic [ENT_W-1:0] owner [NV];
    logic [SUB_W-1:0] subch [NV];
    logic [END_W-1:0] end_time [NV];
    logic             active [NV];
    logic [ENT_W-1:0] listener;
    outcome_t         pending [$];
    int unsigned      checked;
    int unsigned      mismatches;

    function new();
      clear_table();
      listener   = '0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void clear_table();
      foreach (owner[i]) begin
        owner[i]    = '0;
        subch[i]    = '0;
        end_time[i] = '0;
        active[i]   = 1'b0;
      end
    endfunction

    function void note_request(request_t r);
      outcome_t res;
      int       winner;
      longint   best_life;
      longint   life;
      res = '0;
      case (r.kind)
        REQ_ALLOC: begin
          winner    = -1;
          best_life = 64'sh7fff_ffff;
          for (int i = 0; i < NV; i++) begin
            if (r.chan != SUB_NEVER && owner[i] == r.entity &&
                (subch[i] == r.chan || r.chan == SUB_ANY)) begin
              winner = i;
              break;
            end
            // listener's live voices are off limits to everyone else
            if (owner[i] == listener && r.entity != listener && active[i])
              continue;
            life = longint'({32'd0, end_time[i]}) - longint'({33'd0, r.now});
            if (life < best_life) begin
              best_life = life;
              winner    = i;
            end
          end
          if (winner >= 0) begin
            owner[winner]    = r.entity;
            subch[winner]    = r.chan;
            end_time[winner] = {1'b0, r.now} + END_W'(r.len);
            active[winner]   = 1'b1;
            res.found        = 1'b1;
            res.idx          = VIDX_W'(winner);
          end
        end
        REQ_STOP: begin
          for (int i = 0; i < NV; i++) begin
            if (owner[i] == r.entity && subch[i] == r.chan) begin
              end_time[i] = '0;
              active[i]   = 1'b0;
              res.found   = 1'b1;
              res.idx     = VIDX_W'(i);
              break;
            end
          end
        end
        REQ_CLEAR: clear_table();
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic found, logic [VIDX_W-1:0] idx);
      outcome_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: found=%0d voice_index=%0d", found, idx);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        mismatches++;
      end
      if (idx !== want.idx) begin
        $error("voice_index: expected %0d, actual %0d", want.idx, idx);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ENT_W-1:0] cfg_wdata_i;

  sca_in_if  in_if ();
  sca_out_if out_if ();

  sound_channel_allocator_core #(
    .NUM_VOICES(NV)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  voice_alloc_scoreboard sb = new();

  int unsigned       idle_pct  = 0;
  int unsigned       stall_pct = 0;
  logic [TIME_W-1:0] cur_time  = '0;
  int unsigned       n_req     = 0;
  int unsigned       n_alloc   = 0;
  int unsigned       n_stop    = 0;

  always #5 clk_i = ~clk_i;

  // result side: random back-pressure, check every accepted item
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        sb.check_result(out_if.found, out_if.voice_index);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("sound_channel_allocator_core verification failed");
    $finish;
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        idle_pct  = 12;
        stall_pct = 66;
      end
      1: begin
        idle_pct  = 66;
        stall_pct = 12;
      end
      default: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic write_listener(input logic [ENT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.listener = value;
  endtask

  task automatic send_request(input request_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_if.valid        <= 1'b1;
    in_if.req_type     <= r.kind;
    in_if.entity       <= r.entity;
    in_if.ent_channel  <= r.chan;
    in_if.now_time     <= r.now;
    in_if.sound_length <= r.len;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_request(r);
    n_req++;
    if (r.kind == REQ_ALLOC) n_alloc++;
    if (r.kind == REQ_STOP) n_stop++;
  endtask

  // block is idle once every result is back and the chain has emptied
  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (NV + 4) @(posedge clk_i);
  endtask

  function automatic request_t mk_req(req_e kind, logic [ENT_W-1:0] ent, int chan,
                                      logic [TIME_W-1:0] now, logic [LEN_W-1:0] len);
    request_t r;
    r.kind   = kind;
    r.entity = ent;
    r.chan   = SUB_W'(chan);
    r.now    = now;
    r.len    = len;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       slot;
    pick = $urandom_range(99);
    if (pick < 62)      r.kind = REQ_ALLOC;
    else if (pick < 93) r.kind = REQ_STOP;
    else if (pick < 96) r.kind = REQ_CLEAR;
    else                r.kind = REQ_NONE;
    // small entity pool so reuse and protection actually happen
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2: r.entity = sb.listener;
      3:       r.entity = 16'h0001;
      4:       r.entity = 16'h0002;
      5:       r.entity = 16'h0003;
      6:       r.entity = 16'hFFFF;
      7:       r.entity = 16'h8000;
      default: r.entity = ENT_W'($urandom);
    endcase
    r.chan = SUB_W'($urandom_range(8) - 1);
    if (r.kind == REQ_STOP && $urandom_range(9) < 7) begin
      slot     = $urandom_range(NV - 1);
      r.entity = sb.owner[slot];
      r.chan   = sb.subch[slot];
    end
    // mostly advancing time, now and then a jump anywhere
    if ($urandom_range(9) == 0) cur_time = TIME_W'($urandom);
    else                        cur_time = cur_time + TIME_W'($urandom_range(2000));
    r.now = cur_time;
    if ($urandom_range(4) == 0) r.len = LEN_W'($urandom);
    else                        r.len = LEN_W'($urandom_range(5000));
    return r;
  endfunction

  initial begin
    request_t         directed [$];
    logic [ENT_W-1:0] lst;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_NONE;
    in_if.entity       = '0;
    in_if.ent_channel  = '0;
    in_if.now_time     = '0;
    in_if.sound_length = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    write_listener(16'h0005);
    directed.push_back(mk_req(REQ_CLEAR, 16'h0000, 0, 31'd0, 24'd0));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0005, 1, 31'd100, 24'd1000));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0007, 2, 31'd100, 24'd50));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0007, 2, 31'd120, 24'd60));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0007, -1, 31'd130, 24'd70));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0007, 0, 31'd140, 24'd80));
    directed.push_back(mk_req(REQ_STOP, 16'h0007, 2, 31'd150, 24'd0));
    directed.push_back(mk_req(REQ_STOP, 16'h0009, 3, 31'd150, 24'd0));
    // stop hits a voice that was never started
    directed.push_back(mk_req(REQ_STOP, 16'h0000, 0, 31'd160, 24'd0));
    directed.push_back(mk_req(REQ_NONE, 16'hFFFF, -1, 31'h7FFF_FFFF, 24'hFF_FFFF));
    directed.push_back(mk_req(REQ_ALLOC, 16'hFFFF, 7, 31'h7FFF_FFFF, 24'hFF_FFFF));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0000, -1, 31'd0, 24'd0));
    directed.push_back(mk_req(REQ_CLEAR, 16'h0000, 0, 31'd0, 24'd0));
    // listener fills the whole table, then an outsider finds nothing
    for (int i = 0; i < NV; i++)
      directed.push_back(mk_req(REQ_ALLOC, 16'h0005, 0, 31'd10, LEN_W'(1000 + i)));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0009, 1, 31'd20, 24'd5));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0005, -1, 31'd30, 24'd5));
    directed.push_back(mk_req(REQ_STOP, 16'h0005, 0, 31'd35, 24'd0));
    directed.push_back(mk_req(REQ_ALLOC, 16'h0009, 1, 31'd40, 24'd5));
    foreach (directed[k]) send_request(directed[k]);
    drain_and_settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       lst = 16'h0001;
        1:       lst = 16'hFFFF;
        2:       lst = 16'h0000;
        3:       lst = ENT_W'($urandom);
        4:       lst = 16'h0003;
        default: lst = 16'h8000;
      endcase
      set_idling(phase / 2);
      write_listener(lst);
      repeat (200) send_request(random_request());
      drain_and_settle();
    end

    $display("Ran %0d requests (%0d allocate, %0d stop) over 7 listener values and 3 idling mixes.",
             n_req, n_alloc, n_stop);
    $display("Results checked: %0d, mismatches: %0d.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("sound_channel_allocator_core verification clean");
    else
      $display("sound_channel_allocator_core verification failed");
    $finish;
  end

endmodule
